[src/esd_pkg.sv]
// Package: types, character codes and helper functions of the escape sequence decoder.
package esd_pkg;

	// Depth of the queue between front and back.
	localparam int unsigned ESD_QUEUE_DEPTH = 2;

	// Character codes
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_AT        = 8'h40;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_UP_B      = 8'h42;
	localparam logic [7:0] CH_UP_E      = 8'h45;
	localparam logic [7:0] CH_UP_F      = 8'h46;
	localparam logic [7:0] CH_UP_N      = 8'h4E;
	localparam logic [7:0] CH_UP_R      = 8'h52;
	localparam logic [7:0] CH_UP_S      = 8'h53;
	localparam logic [7:0] CH_UP_T      = 8'h54;
	localparam logic [7:0] CH_UP_X      = 8'h58;
	localparam logic [7:0] CODE_BS      = 8'h08;
	localparam logic [7:0] CODE_FF      = 8'h0C;
	localparam logic [7:0] CODE_LF      = 8'h0A;
	localparam logic [7:0] CODE_CR      = 8'h0D;
	localparam logic [7:0] CODE_SPACE   = 8'h20;
	localparam logic [7:0] CODE_TAB     = 8'h09;
	localparam logic [7:0] CODE_ESC     = 8'h1B;
	localparam logic [7:0] CODE_NUL     = 8'h00;
	localparam logic [7:0] OCT_LIMIT    = 8'h1F;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_CARET  = 3'd2,
		MODE_HEX    = 3'd3,
		MODE_OCT    = 3'd4
	} esd_mode_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_string;
	} esd_in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       run_last;
		logic       string_last;
	} esd_out_t;

	// One queued item: one or two decoded characters.
	typedef struct packed {
		logic       two;
		logic [7:0] first;
		logic [7:0] second;
		logic       eos;
	} esd_entry_t;

	// Queue status seen by front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} esd_qstat_t;

	function automatic logic [7:0] up_case(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - CH_ZERO;
		end else begin
			v = up_case(c) - 8'h41 + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h37;
	endfunction

endpackage

[src/esd_front.sv]
// Front part: accepts raw characters, tracks the escape state and queues decoded characters.
module esd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                raw_valid,
	output logic                raw_stall,
	input  esd_pkg::esd_in_t    raw_item,
	input  esd_pkg::esd_qstat_t qstat,
	output logic                push,
	output esd_pkg::esd_entry_t push_entry
);
	import esd_pkg::*;

	esd_mode_t  mode_q, mode_post, mode_d;
	logic [7:0] acc_q, acc_post, acc_d;
	logic [1:0] cnt_q, cnt_post, cnt_d;

	logic [7:0] c;
	logic       eos;
	logic       accept;
	logic [7:0] hex_acc, oct_acc;
	logic [1:0] hex_cnt, oct_cnt;
	logic       hex_full, oct_full;
	logic [1:0] n_res;
	logic [7:0] res0, res1;

	assign c         = raw_item.char_in;
	assign eos       = raw_item.end_of_string;
	assign raw_stall = qstat.full;
	assign accept    = raw_valid && !qstat.full;

	// Digit accumulation for the hex and octal runs
	assign hex_acc  = {acc_q[3:0], hex_val(c)};
	assign hex_cnt  = cnt_q + 2'd1;
	assign hex_full = hex_cnt >= 2'd2;
	assign oct_acc  = {acc_q[4:0], c[2:0]};
	assign oct_cnt  = cnt_q + 2'd1;
	assign oct_full = oct_cnt == 2'd3 || oct_cnt == 2'd0 || oct_acc > OCT_LIMIT;

	// Next state before the end-of-string flush
	always_comb begin
		mode_post = MODE_NORMAL;
		acc_post  = '0;
		cnt_post  = '0;
		unique case (mode_q)
			MODE_ESC: begin
				unique case (up_case(c))
					CH_CARET: mode_post = MODE_CARET;
					CH_UP_X:  mode_post = MODE_HEX;
					CH_UP_B, CH_UP_F, CH_UP_N, CH_UP_R,
					CH_UP_S, CH_UP_T, CH_UP_E: mode_post = MODE_NORMAL;
					default: begin
						if (is_oct(c)) begin
							mode_post = MODE_OCT;
							acc_post  = c - CH_ZERO;
							cnt_post  = 2'd1;
						end
					end
				endcase
			end
			MODE_CARET: mode_post = MODE_NORMAL;
			MODE_HEX: begin
				if (is_hex(c)) begin
					if (!hex_full) begin
						mode_post = MODE_HEX;
						acc_post  = hex_acc;
						cnt_post  = hex_cnt;
					end
				end else if (c == CH_BACKSLASH) begin
					mode_post = MODE_ESC;
				end
			end
			MODE_OCT: begin
				if (is_oct(c)) begin
					if (!oct_full) begin
						mode_post = MODE_OCT;
						acc_post  = oct_acc;
						cnt_post  = oct_cnt;
					end
				end else if (c == CH_BACKSLASH) begin
					mode_post = MODE_ESC;
				end
			end
			default: begin
				if (c == CH_BACKSLASH) begin
					mode_post = MODE_ESC;
				end
			end
		endcase
		// Close any open escape at the end of the string
		if (eos) begin
			mode_d = MODE_NORMAL;
			acc_d  = '0;
			cnt_d  = '0;
		end else begin
			mode_d = mode_post;
			acc_d  = acc_post;
			cnt_d  = cnt_post;
		end
	end

	// Decoded characters caused by this item
	always_comb begin
		logic [7:0] v;
		logic       put;
		logic       ret;
		n_res = 2'd0;
		res0  = '0;
		res1  = '0;
		v     = '0;
		put   = 1'b0;
		ret   = 1'b0;
		unique case (mode_q)
			MODE_ESC: begin
				put = 1'b1;
				unique case (up_case(c))
					CH_UP_B: v = CODE_BS;
					CH_UP_F: v = CODE_FF;
					CH_UP_N: v = CODE_LF;
					CH_UP_R: v = CODE_CR;
					CH_UP_S: v = CODE_SPACE;
					CH_UP_T: v = CODE_TAB;
					CH_UP_E: v = CODE_ESC;
					CH_CARET, CH_UP_X: put = 1'b0;
					default: begin
						v   = c;
						put = !is_oct(c);
					end
				endcase
			end
			MODE_CARET: begin
				put = 1'b1;
				v   = (c >= CH_AT) ? up_case(c) - CH_AT : c;
			end
			MODE_HEX: begin
				if (is_hex(c)) begin
					put = hex_full;
					v   = hex_acc;
				end else begin
					put = 1'b1;
					v   = acc_q;
					ret = 1'b1;
				end
			end
			MODE_OCT: begin
				if (is_oct(c)) begin
					put = oct_full;
					v   = oct_acc;
				end else begin
					put = 1'b1;
					v   = acc_q;
					ret = 1'b1;
				end
			end
			default: begin
				put = c != CH_BACKSLASH;
				v   = c;
			end
		endcase
		if (put) begin
			res0  = v;
			n_res = 2'd1;
		end
		// Handle the character that ended a digit run again as plain input
		if (ret && c != CH_BACKSLASH) begin
			res1  = c;
			n_res = 2'd2;
		end
		// Flush an open escape at the end of the string
		if (eos) begin
			put = 1'b1;
			unique case (mode_post)
				MODE_ESC:            v = CH_BACKSLASH;
				MODE_CARET:          v = CODE_NUL;
				MODE_HEX, MODE_OCT:  v = acc_post;
				default: begin
					v   = '0;
					put = 1'b0;
				end
			endcase
			if (put) begin
				if (n_res == 2'd0) begin
					res0  = v;
					n_res = 2'd1;
				end else if (n_res == 2'd1) begin
					res1  = v;
					n_res = 2'd2;
				end
			end
		end
	end

	assign push              = accept && n_res != 2'd0;
	assign push_entry.two    = n_res == 2'd2;
	assign push_entry.first  = res0;
	assign push_entry.second = res1;
	assign push_entry.eos    = eos;

	// Advance the decode state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

[src/esd_queue.sv]
// Queue: short register queue of decoded entries between front and back.
module esd_queue #(
	parameter int unsigned DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  esd_pkg::esd_entry_t push_entry,
	input  logic                pop,
	output esd_pkg::esd_entry_t head,
	output esd_pkg::esd_qstat_t qstat
);
	import esd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	esd_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign qstat.full  = count_q == CNT_FULL;
	assign qstat.empty = count_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = slots_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/esd_back.sv]
// Back part: splits queued entries into single decoded items behind an output register.
module esd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  esd_pkg::esd_entry_t head,
	input  esd_pkg::esd_qstat_t qstat,
	output logic                pop,
	output logic                dec_valid,
	input  logic                dec_stall,
	output esd_pkg::esd_out_t   dec_item
);
	import esd_pkg::*;

	logic     second_q;
	logic     out_valid_q;
	esd_out_t out_q;
	logic     load;
	logic     take;
	logic     last;

	assign load = !out_valid_q || !dec_stall;
	assign take = load && !qstat.empty;
	assign last = !head.two || second_q;
	assign pop  = take && last;

	assign dec_valid = out_valid_q;
	assign dec_item  = out_q;

	// Hold the output item until taken, then load the next character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= !qstat.empty;
			if (take) begin
				second_q <= !last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.char_out    <= second_q ? head.second : head.first;
			out_q.run_last    <= last;
			out_q.string_last <= last && head.eos;
		end
	end

endmodule

[src/escape_sequence_decoder.sv]
// Top level of the escape sequence decoder: front, queue and back.
//
// Raw characters enter on the raw channel (raw_valid, raw_stall, raw_item),
// one per item, with end_of_string on the last character of each string.
// Decoded characters leave on the dec channel (dec_valid, dec_stall,
// dec_item). An item is taken at a rising edge with valid high and stall low.
// An input item gives zero, one or two decoded items; run_last marks the last
// of them and string_last the final decoded character of a string.
// A taken raw item is written into the queue, and dec_valid rises once the
// output register of the back part has been loaded from it.
// Throughput: one raw item per cycle while dec_stall is low and each item
// decodes to at most one character; the two characters of an item leave in
// turn through the single output register of the back part.
// A queue of QUEUE_DEPTH entries sits between front and back; raw_stall rises
// only when it is full, so a stalled receiver backs up into the raw channel
// after the queue and output register have filled. Nothing is lost.
// Reset (arst_n low) empties the queue and output register and returns the
// decoder to normal mode with the digit value and count cleared.
module escape_sequence_decoder #(
	parameter int unsigned QUEUE_DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_valid,
	output logic              raw_stall,
	input  esd_pkg::esd_in_t  raw_item,
	output logic              dec_valid,
	input  logic              dec_stall,
	output esd_pkg::esd_out_t dec_item
);
	import esd_pkg::*;

	esd_qstat_t qstat;
	esd_entry_t push_entry;
	esd_entry_t head;
	logic       push;
	logic       pop;

	esd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw_valid  (raw_valid),
		.raw_stall  (raw_stall),
		.raw_item   (raw_item),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	esd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	esd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

endmodule

[verif/tb.sv]
// Self-checking testbench for the escape sequence decoder: directed strings, random strings.
module tb;
	import esd_pkg::*;

	// Character bounds used by the decoder's own character classes
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;

	localparam int RANDOM_ITEMS  = 850;
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT_CYCLES  = 150000;

	logic      clk;
	logic      arst_n;
	logic      raw_valid;
	logic      raw_stall;
	esd_in_t   raw_item;
	logic      dec_valid;
	logic      dec_stall = 1'b0;
	esd_out_t  dec_item;

	// Decoder state as the testbench sees it
	esd_mode_t  dec_mode  = MODE_NORMAL;
	logic [7:0] dig_value = 8'h00;
	logic [1:0] dig_count = 2'd0;

	esd_out_t   pending_decoded[$];
	logic [7:0] step_chars[$];
	logic [7:0] line_buf[$];
	bit         calm = 1'b0;
	int         items_sent = 0;
	int         error_count = 0;
	string      named_letters = "bfnrtseBFNRTSE";
	string      hex_digits = "0123456789abcdefABCDEF";

	escape_sequence_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_item  (raw_item),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Character classes
	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			return c - 8'h20;
		end
		return c;
	endfunction

	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
			(c >= CH_LOW_A && c <= CH_LOW_F);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else begin
			v = fold_upper(c) - CH_UP_A + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic bit is_oct_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_SEVEN;
	endfunction

	// Emit one decoded character of the current item, two at most
	function automatic void emit(input logic [7:0] c);
		if (step_chars.size() < 2) begin
			step_chars.push_back(c);
		end
	endfunction

	function automatic void back_to_normal();
		dec_mode  = MODE_NORMAL;
		dig_value = 8'h00;
		dig_count = 2'd0;
	endfunction

	function automatic void take_literal(input logic [7:0] c);
		if (c == CH_BACKSLASH) begin
			dec_mode = MODE_ESC;
		end else begin
			emit(c);
		end
	endfunction

	function automatic void take_after_backslash(input logic [7:0] c);
		back_to_normal();
		case (fold_upper(c))
			CH_UP_B: emit(CODE_BS);
			CH_UP_F: emit(CODE_FF);
			CH_UP_N: emit(CODE_LF);
			CH_UP_R: emit(CODE_CR);
			CH_UP_S: emit(CODE_SPACE);
			CH_UP_T: emit(CODE_TAB);
			CH_UP_E: emit(CODE_ESC);
			CH_CARET: dec_mode = MODE_CARET;
			CH_UP_X: dec_mode = MODE_HEX;
			default: begin
				if (is_oct_char(c)) begin
					dec_mode  = MODE_OCT;
					dig_value = c - CH_ZERO;
					dig_count = 2'd1;
				end else begin
					emit(c);
				end
			end
		endcase
	endfunction

	// Work out the decoded items caused by one accepted raw item
	function automatic void decode_item(input esd_in_t item);
		logic [7:0] c;
		esd_out_t   res;
		c = item.char_in;
		step_chars.delete();
		case (dec_mode)
			MODE_ESC: take_after_backslash(c);
			MODE_CARET: begin
				back_to_normal();
				emit(c >= CH_AT ? fold_upper(c) - CH_AT : c);
			end
			MODE_HEX: begin
				if (is_hex_char(c)) begin
					dig_value = {dig_value[3:0], hex_nibble(c)};
					dig_count = dig_count + 2'd1;
					if (dig_count >= 2'd2) begin
						emit(dig_value);
						back_to_normal();
					end
				end else begin
					emit(dig_value);
					back_to_normal();
					take_literal(c);
				end
			end
			MODE_OCT: begin
				if (is_oct_char(c)) begin
					dig_value = {dig_value[4:0], c[2:0]};
					dig_count = dig_count + 2'd1;
					if (dig_count >= 2'd3 || dig_count == 2'd0 || dig_value > OCT_LIMIT) begin
						emit(dig_value);
						back_to_normal();
					end
				end else begin
					emit(dig_value);
					back_to_normal();
					take_literal(c);
				end
			end
			default: begin
				back_to_normal();
				take_literal(c);
			end
		endcase
		// Close any open escape at the end of the string
		if (item.end_of_string) begin
			case (dec_mode)
				MODE_ESC: emit(CH_BACKSLASH);
				MODE_CARET: emit(CODE_NUL);
				MODE_HEX, MODE_OCT: emit(dig_value);
				default: ;
			endcase
			back_to_normal();
		end
		for (int i = 0; i < step_chars.size(); i++) begin
			res.char_out    = step_chars[i];
			res.run_last    = (i == step_chars.size() - 1);
			res.string_last = item.end_of_string && (i == step_chars.size() - 1);
			pending_decoded.push_back(res);
		end
	endfunction

	// Send one raw item, idling at random first; predict once accepted
	task automatic send_char(input logic [7:0] c, input logic eos);
		esd_in_t item;
		item.char_in       = c;
		item.end_of_string = eos;
		while (!calm && $urandom_range(99) < 26) begin
			raw_valid = 1'b0;
			@(negedge clk);
		end
		raw_valid = 1'b1;
		raw_item  = item;
		do @(posedge clk); while (raw_stall);
		decode_item(item);
		items_sent++;
		@(negedge clk);
		raw_valid = 1'b0;
	endtask

	// Send the buffered string, end_of_string on its last character
	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) begin
			send_char(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(s[i]);
		end
	endtask

	// Hold until every predicted item has come out
	task automatic wait_drained();
		while (pending_decoded.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Append one random token: mostly well-formed escapes, some noise and broken ones
	task automatic add_token();
		int         kind;
		int         n;
		logic [7:0] c;
		kind = $urandom_range(99);
		if (kind < 20) begin
			c = 8'($urandom_range(255));
			line_buf.push_back(c == CH_BACKSLASH ? CH_CARET : c);
		end else if (kind < 40) begin
			line_buf.push_back(CH_BACKSLASH);
			line_buf.push_back(named_letters[$urandom_range(13)]);
		end else if (kind < 50) begin
			line_buf.push_back(CH_BACKSLASH);
			line_buf.push_back(CH_CARET);
			line_buf.push_back(8'($urandom_range(255)));
		end else if (kind < 62) begin
			line_buf.push_back(CH_BACKSLASH);
			line_buf.push_back($urandom_range(1) ? CH_UP_X : CH_LOW_X);
			n = $urandom_range(2);
			repeat (n) line_buf.push_back(hex_digits[$urandom_range(21)]);
		end else if (kind < 76) begin
			line_buf.push_back(CH_BACKSLASH);
			n = $urandom_range(3, 1);
			// favour a low first digit so that three-digit runs occur
			c = 8'($urandom_range(1) ? $urandom_range(3) : $urandom_range(7));
			line_buf.push_back(CH_ZERO + c);
			repeat (n - 1) line_buf.push_back(CH_ZERO + 8'($urandom_range(7)));
		end else if (kind < 84) begin
			line_buf.push_back(CH_BACKSLASH);
			line_buf.push_back(8'($urandom_range(255)));
		end else if (kind < 92) begin
			line_buf.push_back(8'($urandom_range(255)));
		end else begin
			line_buf.push_back(CH_BACKSLASH);
			case ($urandom_range(2))
				0: line_buf.push_back(CH_CARET);
				1: line_buf.push_back(CH_LOW_X);
				default: ;
			endcase
		end
	endtask

	// Extremes, named escapes, caret, digit runs and open escapes at the string end
	task automatic test_directed();
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		send_line();
		add_text("\\n\\E");
		send_line();
		add_text("\\^a");
		send_line();
		add_text("\\^");
		send_line();
		add_text("\\x4g");
		send_line();
		add_text("\\0377");
		send_line();
		add_text("\\x");
		send_line();
		line_buf.push_back(CH_BACKSLASH);
		send_line();
		add_text("\\xff");
		send_line();
	endtask

	// Random strings of one to five tokens up to a running item count
	task automatic test_random_strings(input int upto);
		int n;
		while (items_sent < upto) begin
			n = $urandom_range(5, 1);
			repeat (n) add_token();
			send_line();
		end
	endtask

	// Full rate on both sides, no idling at all
	task automatic test_back_to_back(input int count);
		calm = 1'b1;
		test_random_strings(items_sent + count);
		calm = 1'b0;
	endtask

	// Let the output side drain completely before more strings arrive
	task automatic test_drain_pause(input int count);
		test_random_strings(items_sent + count);
		wait_drained();
		test_random_strings(items_sent + count);
	endtask

	// Stall the decoded side at random
	always @(negedge clk) begin
		dec_stall <= !calm && ($urandom_range(99) < 26);
	end

	// Compare each decoded item with the oldest prediction
	always @(posedge clk) begin : check_decoded
		esd_out_t want;
		if (arst_n && dec_valid && !dec_stall) begin
			if (pending_decoded.size() == 0) begin
				error_count++;
				$display("%0t: unexpected decoded item: expected none, actual %h/%b/%b",
					$time, dec_item.char_out, dec_item.run_last, dec_item.string_last);
			end else begin
				want = pending_decoded.pop_front();
				if (dec_item.char_out !== want.char_out || dec_item.run_last !== want.run_last ||
					dec_item.string_last !== want.string_last) begin
					error_count++;
					$display("%0t: decoded item mismatch: expected %h/%b/%b, actual %h/%b/%b",
						$time, want.char_out, want.run_last, want.string_last,
						dec_item.char_out, dec_item.run_last, dec_item.string_last);
				end
			end
		end
	end

	initial begin
		raw_valid = 1'b0;
		raw_item  = '0;
		arst_n    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_strings(450);
		test_back_to_back(150);
		test_drain_pause(60);
		test_random_strings(RANDOM_ITEMS);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** escape_sequence_decoder: PASSED **");
		end else begin
			$display("** escape_sequence_decoder: FAILED **");
		end
		$finish;
	end

	// Guard against a hang
	initial begin
		#(8 * LIMIT_CYCLES);
		$display("** escape_sequence_decoder: FAILED **");
		$finish;
	end

endmodule
